[src/lrw_pkg.sv]
// Shared types, codes and defaults for the lattice random walk step block.
// Used by lrw_decode, lattice_random_walk_step, walk_checker and testbench; depends on nothing else.
`default_nettype none

package lrw_pkg;

    // Default sizes for the top-level parameters.
    localparam int GRID_MAX_DEF      = 64;
    localparam int MAX_PARTICLES_DEF = 1024;

    // Fixed field widths of the stream items.
    localparam int IDX_W    = 10;
    localparam int CODE_W   = 3;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int STEP_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int GRID_W   = 7;
    localparam int PCOUNT_W = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 1'b1;
    localparam logic [GRID_W-1:0]    GRID_SIZE_RST      = 7'd64;
    localparam logic [PCOUNT_W-1:0]  PCOUNT_RST         = 11'd1024;

    // Request kinds.
    localparam logic REQ_PLACE = 1'b0;
    localparam logic REQ_MOVE  = 1'b1;

    // Move codes.
    localparam logic [CODE_W-1:0] MV_STAY  = 3'd0;
    localparam logic [CODE_W-1:0] MV_UP    = 3'd1;
    localparam logic [CODE_W-1:0] MV_RIGHT = 3'd2;
    localparam logic [CODE_W-1:0] MV_DOWN  = 3'd3;
    localparam logic [CODE_W-1:0] MV_LEFT  = 3'd4;

    // Result status codes.
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_DONE     = 3'd0;
    localparam t_status ST_BORDER   = 3'd1;
    localparam t_status ST_BAD_IDX  = 3'd2;
    localparam t_status ST_BAD_CODE = 3'd3;
    localparam t_status ST_BAD_CELL = 3'd4;

    // What one request does to the stores.
    typedef struct packed {
        t_status status;
        logic    pos_we;    // write the particle's new position
        logic    cnt_dec;   // lower the count of the cell left behind
        logic    cnt_inc;   // raise the count of the cell entered
        logic    step_inc;  // count an accepted move step
    } t_ctrl;

endpackage

`default_nettype wire

[src/lrw_decode.sv]
// Request decode for the lattice random walk: checks and next position.
// Depends on lrw_pkg; purely combinational.
`default_nettype none

module lrw_decode import lrw_pkg::*; #(
    parameter int GRID_MAX      = GRID_MAX_DEF,
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
    localparam int ROW_W        = $clog2(GRID_MAX)
) (
    input  wire logic                req_type,
    input  wire logic [IDX_W-1:0]    particle_index,
    input  wire logic [CODE_W-1:0]   move_code,
    input  wire logic [POS_W-1:0]    place_row,
    input  wire logic [POS_W-1:0]    place_col,
    input  wire logic [ROW_W-1:0]    cur_row,
    input  wire logic [ROW_W-1:0]    cur_col,
    input  wire logic [GRID_W-1:0]   grid_size,
    input  wire logic [PCOUNT_W-1:0] particle_count,
    output t_ctrl                    ctrl,
    output logic      [ROW_W-1:0]    new_row,
    output logic      [ROW_W-1:0]    new_col
);

    localparam int SIDE_W = $clog2(GRID_MAX + 1);

    logic [SIDE_W-1:0] side;
    logic              bad_idx;
    logic              blocked;
    logic [ROW_W-1:0]  mv_row;
    logic [ROW_W-1:0]  mv_col;

    always_comb begin
        if (grid_size == '0) begin
            side = SIDE_W'(1);
        end else if (32'(grid_size) > GRID_MAX) begin
            side = SIDE_W'(GRID_MAX);
        end else begin
            side = SIDE_W'(grid_size);
        end
    end

    assign bad_idx = (32'(particle_index) >= 32'(particle_count)) ||
                     (32'(particle_index) >= MAX_PARTICLES);

    always_comb begin
        blocked = 1'b0;
        mv_row  = cur_row;
        mv_col  = cur_col;
        case (move_code)
            MV_UP: begin
                if (cur_row == '0) blocked = 1'b1;
                else mv_row = cur_row - ROW_W'(1);
            end
            MV_RIGHT: begin
                if (32'(cur_col) + 1 >= 32'(side)) blocked = 1'b1;
                else mv_col = cur_col + ROW_W'(1);
            end
            MV_DOWN: begin
                if (32'(cur_row) + 1 >= 32'(side)) blocked = 1'b1;
                else mv_row = cur_row + ROW_W'(1);
            end
            MV_LEFT: begin
                if (cur_col == '0) blocked = 1'b1;
                else mv_col = cur_col - ROW_W'(1);
            end
            default: begin
                blocked = 1'b0;
            end
        endcase
    end

    always_comb begin
        ctrl    = '0;
        new_row = cur_row;
        new_col = cur_col;
        if (bad_idx) begin
            ctrl.status = ST_BAD_IDX;
            new_row     = '0;
            new_col     = '0;
        end else if (req_type == REQ_PLACE) begin
            if (32'(place_row) >= 32'(side) || 32'(place_col) >= 32'(side)) begin
                ctrl.status = ST_BAD_CELL;
            end else begin
                // A re-placed particle leaves its old cell count as it was.
                ctrl.status  = ST_DONE;
                ctrl.pos_we  = 1'b1;
                ctrl.cnt_inc = 1'b1;
                new_row      = ROW_W'(place_row);
                new_col      = ROW_W'(place_col);
            end
        end else if (move_code > MV_LEFT) begin
            ctrl.status = ST_BAD_CODE;
        end else if (32'(cur_row) >= 32'(side) || 32'(cur_col) >= 32'(side)) begin
            ctrl.status = ST_BAD_CELL;
        end else if (blocked) begin
            ctrl.status = ST_BORDER;
        end else begin
            ctrl.status   = ST_DONE;
            ctrl.step_inc = 1'b1;
            if (move_code != MV_STAY) begin
                ctrl.pos_we  = 1'b1;
                ctrl.cnt_dec = 1'b1;
                ctrl.cnt_inc = 1'b1;
                new_row      = mv_row;
                new_col      = mv_col;
            end
        end
    end

endmodule

`default_nettype wire

[src/lattice_random_walk_step.sv]
// Top level of the lattice random walk step block: stores, sequencer, ports.
// Depends on lrw_pkg and lrw_decode.
`default_nettype none

// Keeps a GRID_MAX x GRID_MAX grid of cell counts and a position table for
// MAX_PARTICLES particles, both in synchronous memories. Each request (place
// or move) passes through these steps in turn: the transfer, in which the
// particle's position is read; decode and read of the two cell counts; write
// of the position and the lowered old count; and write of the raised new count
// with the result registered. The single write port of the count memory and the
// read-before-write of the position keep requests from overlapping, so a new
// request is taken only after the last one's result is registered; a result
// that is not taken holds the block in its last step only while the previous
// result is still waiting. After reset the count memory is cleared one entry a
// cycle, all GRID_MAX*GRID_MAX entries (4096 by default), during which no
// request is taken; configuration writes are accepted at any time.
module lattice_random_walk_step import lrw_pkg::*; #(
    parameter int GRID_MAX      = GRID_MAX_DEF,
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write channel.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Request stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [9:0] particle_index, [12:10] move_code, [18:13] place_row,
    // [24:19] place_col, [31:25] zero
    input  wire logic [31:0]           s_axis_tdata,
    // [0] req_type
    input  wire logic [0:0]            s_axis_tuser,
    // Result stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [5:0] new_row, [11:6] new_col, [43:12] step_total, [47:44] zero
    output logic      [47:0]           m_axis_tdata,
    // [2:0] status
    output logic      [2:0]            m_axis_tuser
);

    localparam int ROW_W   = $clog2(GRID_MAX);
    localparam int CELLS   = GRID_MAX * GRID_MAX;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int PA_W    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_POS,
        S_CELL,
        S_DONE
    } t_state;

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                     input logic [ROW_W-1:0] col);
        cell_addr = CELL_AW'(32'(row) * GRID_MAX + 32'(col));
    endfunction

    // Memories.
    logic [COUNT_W-1:0]   count_mem [CELLS];
    logic [2*ROW_W-1:0]   pos_mem   [MAX_PARTICLES];

    t_state               r_state;
    logic [CELL_AW-1:0]   r_clr_addr;
    logic [GRID_W-1:0]    r_grid_size;
    logic [PCOUNT_W-1:0]  r_pcount;
    logic [STEP_W-1:0]    r_step;

    // Captured request.
    logic                 r_req_type;
    logic [IDX_W-1:0]     r_pidx;
    logic [CODE_W-1:0]    r_code;
    logic [POS_W-1:0]     r_prow;
    logic [POS_W-1:0]     r_pcol;

    // Decode results.
    t_ctrl                r_ctrl;
    logic [ROW_W-1:0]     r_new_row;
    logic [ROW_W-1:0]     r_new_col;
    logic [CELL_AW-1:0]   r_old_addr;
    logic [CELL_AW-1:0]   r_new_addr;
    logic [COUNT_W-1:0]   r_inc_val;

    // Memory read data.
    logic [2*ROW_W-1:0]   r_pos_q;
    logic [COUNT_W-1:0]   r_old_q;
    logic [COUNT_W-1:0]   r_new_q;

    // Result register.
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [POS_W-1:0]     r_out_row;
    logic [POS_W-1:0]     r_out_col;
    logic [STEP_W-1:0]    r_out_step;

    logic                 in_fire;
    logic                 slot_free;
    t_ctrl                dec_ctrl;
    logic [ROW_W-1:0]     dec_row;
    logic [ROW_W-1:0]     dec_col;
    logic [ROW_W-1:0]     cur_row;
    logic [ROW_W-1:0]     cur_col;
    logic [CELL_AW-1:0]   rd_old_addr;
    logic [CELL_AW-1:0]   rd_new_addr;
    logic [PA_W-1:0]      rd_paddr;
    logic [PA_W-1:0]      wr_paddr;
    logic                 cnt_we;
    logic [CELL_AW-1:0]   cnt_waddr;
    logic [COUNT_W-1:0]   cnt_wdata;
    logic [COUNT_W-1:0]   dec_val;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {4'b0, r_out_step, r_out_col, r_out_row};

    assign cur_row = r_pos_q[2*ROW_W-1:ROW_W];
    assign cur_col = r_pos_q[ROW_W-1:0];

    lrw_decode #(
        .GRID_MAX      (GRID_MAX),
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_decode (
        .req_type       (r_req_type),
        .particle_index (r_pidx),
        .move_code      (r_code),
        .place_row      (r_prow),
        .place_col      (r_pcol),
        .cur_row        (cur_row),
        .cur_col        (cur_col),
        .grid_size      (r_grid_size),
        .particle_count (r_pcount),
        .ctrl           (dec_ctrl),
        .new_row        (dec_row),
        .new_col        (dec_col)
    );

    assign rd_old_addr = cell_addr(cur_row, cur_col);
    assign rd_new_addr = cell_addr(dec_row, dec_col);
    assign rd_paddr    = PA_W'(s_axis_tdata[IDX_W-1:0]);
    assign wr_paddr    = PA_W'(r_pidx);
    assign dec_val     = (r_old_q != '0) ? r_old_q - COUNT_W'(1) : r_old_q;

    // Count memory write port: clearing pass, old-cell decrement, new-cell increment.
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_new_addr;
        cnt_wdata = r_inc_val;
        case (r_state)
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr_addr;
                cnt_wdata = '0;
            end
            S_CELL: begin
                cnt_we    = r_ctrl.cnt_dec;
                cnt_waddr = r_old_addr;
                cnt_wdata = dec_val;
            end
            S_DONE: begin
                cnt_we    = r_ctrl.cnt_inc && slot_free;
            end
            default: begin
                cnt_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (r_state == S_POS) begin
            r_old_q <= count_mem[rd_old_addr];
            r_new_q <= count_mem[rd_new_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CELL && r_ctrl.pos_we) begin
            pos_mem[wr_paddr] <= {r_new_row, r_new_col};
        end
        if (in_fire) begin
            r_pos_q <= pos_mem[rd_paddr];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_SIZE_RST;
            r_pcount    <= PCOUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRID_SIZE:      r_grid_size <= i_cfg_data[GRID_W-1:0];
                CFG_PARTICLE_COUNT: r_pcount    <= i_cfg_data[PCOUNT_W-1:0];
                default:            r_pcount    <= r_pcount;
            endcase
        end
    end

    // Payload registers along the request path.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req_type <= s_axis_tuser[0];
            r_pidx     <= s_axis_tdata[9:0];
            r_code     <= s_axis_tdata[12:10];
            r_prow     <= s_axis_tdata[18:13];
            r_pcol     <= s_axis_tdata[24:19];
        end
        if (r_state == S_POS) begin
            r_ctrl     <= dec_ctrl;
            r_new_row  <= dec_row;
            r_new_col  <= dec_col;
            r_old_addr <= rd_old_addr;
            r_new_addr <= rd_new_addr;
        end
        if (r_state == S_CELL) begin
            r_inc_val <= (r_new_q < COUNT_MAX) ? r_new_q + COUNT_W'(1) : r_new_q;
        end
    end

    // Sequencer, step counter and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the last step the result register is either refilled or held.
            if (r_out_valid && m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + CELL_AW'(1);
                    if (r_clr_addr == CELL_AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    if (r_ctrl.step_inc) begin
                        r_step <= r_step + STEP_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Wait here only while an earlier result still fills the slot.
                    if (slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_ctrl.status;
                        r_out_row    <= POS_W'(r_new_row);
                        r_out_col    <= POS_W'(r_new_col);
                        r_out_step   <= r_step;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[dv/walk_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for lattice_random_walk_step: watches the register, request and result
// channels, predicts each result and compares it field by field. Depends on lrw_pkg.
module walk_checker import lrw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [31:0]           i_req_data,
    input  logic [0:0]            i_req_user,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [47:0]           i_res_data,
    input  logic [2:0]            i_res_user,
    output int                    o_pending,
    output int                    o_errors
);

    localparam int SIDE_MAX  = GRID_MAX_DEF;
    localparam int SLOTS_MAX = MAX_PARTICLES_DEF;

    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [STEP_W-1:0] steps;
    } t_walk_outcome;

    logic [GRID_W-1:0]   grid_reg;
    logic [PCOUNT_W-1:0] parts_reg;
    logic [POS_W-1:0]    part_row [SLOTS_MAX];
    logic [POS_W-1:0]    part_col [SLOTS_MAX];
    logic [COUNT_W-1:0]  cell_cnt [SIDE_MAX*SIDE_MAX];
    logic [STEP_W-1:0]   step_cnt;
    t_walk_outcome       pending_outcomes [$];

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    function automatic void raise_count(int r, int c);
        int k;
        k = r * SIDE_MAX + c;
        if (cell_cnt[k] != COUNT_MAX) cell_cnt[k] = cell_cnt[k] + 1'b1;
    endfunction

    // Applies one request to the shadow stores and returns what the block should report.
    function automatic t_walk_outcome apply_request(logic req, logic [IDX_W-1:0] idx,
                                                    logic [CODE_W-1:0] code,
                                                    logic [POS_W-1:0] prow,
                                                    logic [POS_W-1:0] pcol);
        t_walk_outcome res;
        int side;
        int npart;
        int r;
        int c;
        int nr;
        int nc;
        bit blocked;
        side  = (grid_reg == 0) ? 1 : ((grid_reg > SIDE_MAX) ? SIDE_MAX : int'(grid_reg));
        npart = (parts_reg > SLOTS_MAX) ? SLOTS_MAX : int'(parts_reg);
        res.status = ST_DONE;
        r = 0;
        c = 0;
        if (int'(idx) >= npart) begin
            res.status = ST_BAD_IDX;
        end else begin
            r = part_row[idx];
            c = part_col[idx];
            if (req == REQ_PLACE) begin
                if (int'(prow) >= side || int'(pcol) >= side) begin
                    res.status = ST_BAD_CELL;
                end else begin
                    // A re-place leaves the old cell's count as it was.
                    part_row[idx] = prow;
                    part_col[idx] = pcol;
                    raise_count(prow, pcol);
                    r = prow;
                    c = pcol;
                end
            end else if (code > MV_LEFT) begin
                res.status = ST_BAD_CODE;
            end else if (r >= side || c >= side) begin
                // The particle was stranded when the grid shrank.
                res.status = ST_BAD_CELL;
            end else begin
                nr = r;
                nc = c;
                blocked = 1'b0;
                case (code)
                    MV_UP: begin
                        if (r == 0) blocked = 1'b1; else nr = r - 1;
                    end
                    MV_RIGHT: begin
                        if (c + 1 >= side) blocked = 1'b1; else nc = c + 1;
                    end
                    MV_DOWN: begin
                        if (r + 1 >= side) blocked = 1'b1; else nr = r + 1;
                    end
                    MV_LEFT: begin
                        if (c == 0) blocked = 1'b1; else nc = c - 1;
                    end
                    default: ;
                endcase
                if (blocked) begin
                    res.status = ST_BORDER;
                end else begin
                    if (code != MV_STAY) begin
                        if (cell_cnt[r * SIDE_MAX + c] != 0)
                            cell_cnt[r * SIDE_MAX + c] = cell_cnt[r * SIDE_MAX + c] - 1'b1;
                        raise_count(nr, nc);
                        part_row[idx] = nr[POS_W-1:0];
                        part_col[idx] = nc[POS_W-1:0];
                        r = nr;
                        c = nc;
                    end
                    step_cnt = step_cnt + 1'b1;
                end
            end
        end
        res.row   = r[POS_W-1:0];
        res.col   = c[POS_W-1:0];
        res.steps = step_cnt;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            o_errors++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_walk_outcome want;
        if (!i_rst_n) begin
            grid_reg  = GRID_SIZE_RST;
            parts_reg = PCOUNT_RST;
            step_cnt  = '0;
            for (int i = 0; i < SIDE_MAX * SIDE_MAX; i++) cell_cnt[i] = '0;
            for (int i = 0; i < SLOTS_MAX; i++) begin
                part_row[i] = '0;
                part_col[i] = '0;
            end
            pending_outcomes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_GRID_SIZE) grid_reg = i_cfg_data[GRID_W-1:0];
                else parts_reg = i_cfg_data[PCOUNT_W-1:0];
            end
            if (i_res_valid && i_res_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected result, status %0d row %0d col %0d steps %0d",
                             $time, i_res_user, i_res_data[5:0], i_res_data[11:6],
                             i_res_data[43:12]);
                    o_errors++;
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("status", want.status, i_res_user);
                    check_field("new_row", want.row, i_res_data[5:0]);
                    check_field("new_col", want.col, i_res_data[11:6]);
                    check_field("step_total", want.steps, i_res_data[43:12]);
                end
            end
            if (i_req_valid && i_req_ready)
                pending_outcomes.push_back(apply_request(i_req_user[0], i_req_data[9:0],
                                                         i_req_data[12:10], i_req_data[18:13],
                                                         i_req_data[24:19]));
        end
        o_pending = pending_outcomes.size();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top of the lattice_random_walk_step bench: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Depends on lrw_pkg and walk_checker.
module testbench;
    import lrw_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam logic [CODE_W-1:0] MV_BAD_FIRST = MV_LEFT + 3'd1;
    localparam logic [CODE_W-1:0] MV_BAD_LAST  = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [47:0]           m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    int                    chk_pending;
    int                    chk_errors;

    // Stimulus-side view of the configuration and of which particles have a position.
    int side_now  = GRID_MAX_DEF;
    int parts_now = MAX_PARTICLES_DEF;
    int pool_size = MAX_PARTICLES_DEF;
    int burst_left = 0;
    bit placed [MAX_PARTICLES_DEF];
    int rx_mode = 0;
    int rx_left = 0;

    lattice_random_walk_step dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    walk_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_req_valid(s_axis_tvalid),
        .i_req_ready(s_axis_tready),
        .i_req_data (s_axis_tdata),
        .i_req_user (s_axis_tuser),
        .i_res_valid(m_axis_tvalid),
        .i_res_ready(m_axis_tready),
        .i_res_data (m_axis_tdata),
        .i_res_user (m_axis_tuser),
        .o_pending  (chk_pending),
        .o_errors   (chk_errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("%0t: run did not finish in time", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result back-pressure: each stretch picks its own stall pattern.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 200);
        end
        rx_left--;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_left % 3 != 0);
        endcase
    end

    task automatic send_request(input logic req, input logic [IDX_W-1:0] idx,
                                input logic [CODE_W-1:0] code, input logic [POS_W-1:0] row,
                                input logic [POS_W-1:0] col);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, col, row, code, idx};
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        if (req == REQ_PLACE && idx < parts_now && row < side_now && col < side_now)
            placed[idx] = 1'b1;
    endtask

    // Stops the request stream and waits until every result has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (chk_pending != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index == CFG_GRID_SIZE) begin
            side_now = (value[GRID_W-1:0] == 0) ? 1 :
                       ((value[GRID_W-1:0] > GRID_MAX_DEF) ? GRID_MAX_DEF :
                        int'(value[GRID_W-1:0]));
        end else begin
            parts_now = (value > MAX_PARTICLES_DEF) ? MAX_PARTICLES_DEF : int'(value);
        end
    endtask

    // The grid register only holds seven bits, so the spare data bits are randomized.
    task automatic reconfigure(input int grid, input int parts);
        drain_results();
        write_register(CFG_GRID_SIZE, {4'($urandom), 7'(grid)});
        write_register(CFG_PARTICLE_COUNT, 11'(parts));
    endtask

    // Mostly moves of placed particles; places fill the pool, a few bad indexes and cells.
    task automatic random_request();
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        int roll;
        bit found;
        code = $urandom;
        row  = $urandom;
        col  = $urandom;
        roll = $urandom_range(0, 99);
        found = 1'b0;
        if (parts_now == 0 || (roll < 6 && parts_now < MAX_PARTICLES_DEF)) begin
            idx = $urandom_range(parts_now, MAX_PARTICLES_DEF - 1);
            send_request(1'($urandom_range(0, 1)), idx, code, row, col);
        end else begin
            if (roll >= 30) begin
                repeat (8) begin
                    if (!found) begin
                        idx = $urandom_range(0, pool_size - 1);
                        found = placed[idx];
                    end
                end
            end
            if (found) begin
                code = ($urandom_range(0, 15) == 0) ? $urandom_range(MV_BAD_FIRST, MV_BAD_LAST)
                                                    : $urandom_range(MV_STAY, MV_LEFT);
                send_request(REQ_MOVE, idx, code, row, col);
            end else begin
                idx = $urandom_range(0, pool_size - 1);
                // A place outside the grid reports the stored position, so only placed ones.
                if (!($urandom_range(0, 9) == 0 && placed[idx])) begin
                    row = $urandom_range(0, side_now - 1);
                    col = $urandom_range(0, side_now - 1);
                end
                send_request(REQ_PLACE, idx, code, row, col);
            end
        end
    endtask

    initial begin
        int grid;
        int parts;
        int count;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_GRID_SIZE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_PLACE;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corners and borders on the full grid with the reset configuration.
        send_request(REQ_PLACE, 10'd0, 3'($urandom), 6'd0, 6'd0);
        send_request(REQ_PLACE, 10'd1023, 3'($urandom), 6'd63, 6'd63);
        send_request(REQ_PLACE, 10'd682, 3'($urandom), 6'd42, 6'd21);
        send_request(REQ_PLACE, 10'd341, 3'($urandom), 6'd21, 6'd42);
        send_request(REQ_MOVE, 10'd0, MV_UP, 6'($urandom), 6'($urandom));
        send_request(REQ_MOVE, 10'd0, MV_LEFT, 6'($urandom), 6'($urandom));
        send_request(REQ_MOVE, 10'd0, MV_STAY, 6'($urandom), 6'($urandom));
        send_request(REQ_MOVE, 10'd0, MV_RIGHT, 6'($urandom), 6'($urandom));
        send_request(REQ_MOVE, 10'd0, MV_DOWN, 6'($urandom), 6'($urandom));
        send_request(REQ_MOVE, 10'd1023, MV_DOWN, 6'($urandom), 6'($urandom));
        send_request(REQ_MOVE, 10'd1023, MV_RIGHT, 6'($urandom), 6'($urandom));
        send_request(REQ_MOVE, 10'd1023, MV_UP, 6'($urandom), 6'($urandom));
        send_request(REQ_MOVE, 10'd682, MV_BAD_FIRST, 6'($urandom), 6'($urandom));
        send_request(REQ_MOVE, 10'd341, MV_BAD_LAST, 6'($urandom), 6'($urandom));
        send_request(REQ_PLACE, 10'd0, 3'($urandom), 6'd5, 6'd5);

        // A particle count of one, then a grid that strands particle 0.
        reconfigure(8, 1);
        send_request(REQ_PLACE, 10'd1, 3'($urandom), 6'd1, 6'd1);
        send_request(REQ_MOVE, 10'd1023, MV_UP, 6'($urandom), 6'($urandom));
        send_request(REQ_PLACE, 10'd0, 3'($urandom), 6'd8, 6'd3);
        send_request(REQ_MOVE, 10'd0, MV_DOWN, 6'($urandom), 6'($urandom));
        reconfigure(4, 1024);
        send_request(REQ_MOVE, 10'd0, MV_BAD_LAST, 6'($urandom), 6'($urandom));
        send_request(REQ_MOVE, 10'd0, MV_UP, 6'($urandom), 6'($urandom));
        send_request(REQ_PLACE, 10'd1023, 3'($urandom), 6'd2, 6'd3);
        reconfigure(64, 0);
        send_request(REQ_MOVE, 10'd0, MV_STAY, 6'($urandom), 6'($urandom));
        // A zero grid size works as a single cell.
        reconfigure(0, 2047);
        send_request(REQ_PLACE, 10'd682, 3'($urandom), 6'd0, 6'd0);
        send_request(REQ_MOVE, 10'd682, MV_RIGHT, 6'($urandom), 6'($urandom));
        send_request(REQ_MOVE, 10'd682, MV_DOWN, 6'($urandom), 6'($urandom));
        send_request(REQ_MOVE, 10'd682, MV_STAY, 6'($urandom), 6'($urandom));

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0:  begin grid = 64;  parts = 1024; end
                1:  begin grid = 3;   parts = 4;    end
                2:  begin grid = 1;   parts = 1;    end
                3:  begin grid = 8;   parts = 2047; end
                4:  begin grid = 127; parts = 16;   end
                5:  begin grid = 2;   parts = 1024; end
                6:  begin grid = 16;  parts = 0;    end
                7:  begin grid = 64;  parts = 300;  end
                8:  begin grid = 5;   parts = 2;    end
                9:  begin grid = 0;   parts = 1025; end
                10: begin grid = $urandom_range(1, 127); parts = $urandom_range(1, 2047); end
                default: begin grid = 64; parts = 1024; end
            endcase
            reconfigure(grid, parts);
            if (parts_now == 0) pool_size = 0;
            else if ($urandom_range(0, 2) == 0) pool_size = parts_now;
            else pool_size = (parts_now < 24) ? parts_now : 24;
            count = (parts_now == 0 || side_now == 1) ? 30 : 190;
            repeat (count) begin
                if ($urandom_range(0, 99) == 0) drain_results();
                random_request();
            end
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
